### rtl/lfsp_pkg.sv
package lfsp_pkg;

	// delimiters of the link-format grammar
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// input mode codes; any other code ends the payload without a byte
	localparam logic [1:0] MODE_DATA  = 2'd0;
	localparam logic [1:0] MODE_FINAL = 2'd1;

	// event kinds
	localparam logic [2:0] EV_PATH     = 3'd0;
	localparam logic [2:0] EV_RES_END  = 3'd1;
	localparam logic [2:0] EV_NAME     = 3'd2;
	localparam logic [2:0] EV_VALUE    = 3'd3;
	localparam logic [2:0] EV_ATTR_END = 3'd4;
	localparam logic [2:0] EV_OK       = 3'd5;
	localparam logic [2:0] EV_ERROR    = 3'd6;

	localparam int NUM_SLOTS = 3;

	typedef enum logic [7:0] {
		ST_START      = 8'b0000_0001,
		ST_PATH       = 8'b0000_0010,
		ST_AFTER_RES  = 8'b0000_0100,
		ST_NAME       = 8'b0000_1000,
		ST_VAL_FIRST  = 8'b0001_0000,
		ST_VAL_PLAIN  = 8'b0010_0000,
		ST_VAL_QUOTED = 8'b0100_0000,
		ST_ERROR      = 8'b1000_0000
	} pstate_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] chr;
	} event_t;

	// events caused by one input byte, slot 0 goes out first
	typedef struct packed {
		event_t [NUM_SLOTS-1:0] ev;
		logic [1:0]             cnt;
	} bundle_t;

endpackage

### rtl/lfsp_parser.sv
module lfsp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       mode,
	input  logic [7:0]       data_byte,
	output lfsp_pkg::bundle_t bundle
);
	import lfsp_pkg::*;

	pstate_t state_q, state_d;
	logic    seen_q, seen_d;

	always_comb begin
		event_t     bev;
		logic       bvalid;
		pstate_t    st;
		logic       seen;
		logic       attr_v;
		logic       stat_v;
		logic [2:0] stat_kind;
		logic       ok;
		logic [1:0] k;

		bev       = '0;
		bvalid    = 1'b0;
		st        = state_q;
		seen      = seen_q;
		attr_v    = 1'b0;
		stat_v    = 1'b0;
		stat_kind = EV_OK;
		ok        = 1'b1;

		if (mode == MODE_DATA || mode == MODE_FINAL) begin
			unique case (state_q)
				ST_START: begin
					st = (data_byte == CH_LT) ? ST_PATH : ST_ERROR;
				end
				ST_PATH: begin
					bvalid = 1'b1;
					if (data_byte == CH_GT) begin
						bev.kind = EV_RES_END;
						st       = ST_AFTER_RES;
					end else begin
						bev.kind = EV_PATH;
						bev.chr  = data_byte;
					end
				end
				ST_AFTER_RES: begin
					seen = 1'b0;
					if (data_byte == CH_SEMI)
						st = ST_NAME;
					else if (data_byte == CH_COMMA)
						st = ST_START;
					else
						st = ST_ERROR;
				end
				ST_NAME: begin
					if (data_byte == CH_EQ) begin
						st = seen_q ? ST_VAL_FIRST : ST_ERROR;
					end else if (data_byte == CH_SEMI) begin
						bvalid   = 1'b1;
						bev.kind = EV_ATTR_END;
						seen     = 1'b0;
					end else if (data_byte == CH_COMMA) begin
						bvalid   = 1'b1;
						bev.kind = EV_ATTR_END;
						st       = ST_START;
					end else begin
						bvalid   = 1'b1;
						bev.kind = EV_NAME;
						bev.chr  = data_byte;
						seen     = 1'b1;
					end
				end
				ST_VAL_FIRST, ST_VAL_PLAIN: begin
					bvalid = 1'b1;
					if (state_q == ST_VAL_FIRST && data_byte == CH_QUOTE) begin
						bvalid = 1'b0;
						st     = ST_VAL_QUOTED;
					end else if (data_byte == CH_COMMA) begin
						bev.kind = EV_ATTR_END;
						st       = ST_START;
					end else if (data_byte == CH_SEMI) begin
						bev.kind = EV_ATTR_END;
						seen     = 1'b0;
						st       = ST_NAME;
					end else begin
						bev.kind = EV_VALUE;
						bev.chr  = data_byte;
						st       = ST_VAL_PLAIN;
					end
				end
				ST_VAL_QUOTED: begin
					bvalid = 1'b1;
					if (data_byte == CH_QUOTE) begin
						bev.kind = EV_ATTR_END;
						st       = ST_AFTER_RES;
					end else begin
						bev.kind = EV_VALUE;
						bev.chr  = data_byte;
					end
				end
				default: st = ST_ERROR;
			endcase
		end

		// end of payload: close a pending attribute, then report status
		if (mode != MODE_DATA) begin
			unique case (st)
				ST_START, ST_AFTER_RES: ;
				ST_NAME:                attr_v = seen;
				ST_VAL_FIRST, ST_VAL_PLAIN: attr_v = 1'b1;
				default:                ok = 1'b0;
			endcase
			stat_v    = 1'b1;
			stat_kind = ok ? EV_OK : EV_ERROR;
			st        = ST_START;
			seen      = 1'b0;
		end

		state_d = st;
		seen_d  = seen;

		bundle.ev = '0;
		k = 2'd0;
		if (bvalid) begin
			bundle.ev[k] = bev;
			k = k + 2'd1;
		end
		if (attr_v) begin
			bundle.ev[k].kind = EV_ATTR_END;
			k = k + 2'd1;
		end
		if (stat_v) begin
			bundle.ev[k].kind = stat_kind;
			k = k + 2'd1;
		end
		bundle.cnt = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			seen_q  <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			seen_q  <= seen_d;
		end
	end

	a_end_to_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode != MODE_DATA |=> state_q == ST_START && !seen_q)
		else $error("parser not back at start after end of payload");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q == ST_ERROR && mode == MODE_DATA |-> bundle.cnt == 2'd0)
		else $error("events produced in the error state");

endmodule

### rtl/lfsp_serializer.sv
module lfsp_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lfsp_pkg::bundle_t bundle,
	output logic              take_ok,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // event_byte
	output logic [2:0]        m_tuser,   // event_kind
	output logic              m_tlast    // last_of_run
);
	import lfsp_pkg::*;

	event_t [NUM_SLOTS-1:0] slots_q;
	logic [1:0]             rem_q;
	logic                   xfer;

	assign m_tvalid = rem_q != 2'd0;
	assign m_tuser  = slots_q[0].kind;
	assign m_tdata  = slots_q[0].chr;
	assign m_tlast  = rem_q == 2'd1;
	assign xfer     = m_tvalid && m_tready;
	// a new bundle fits once the current one is gone or leaves this cycle
	assign take_ok  = rem_q == 2'd0 || (rem_q == 2'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= bundle.cnt;
		end else if (xfer) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= bundle.ev;
		end else if (xfer) begin
			slots_q[0] <= slots_q[1];
			slots_q[1] <= slots_q[2];
		end
	end

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_OK || m_tuser == EV_ERROR) |-> m_tlast)
		else $error("status event not the last of its run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !m_tlast |=> m_tvalid)
		else $error("run broken before its last transfer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> rem_q == 2'd0 || (rem_q == 2'd1 && xfer))
		else $error("pending events overwritten");

endmodule

### rtl/link_format_stream_parser_core.sv
// Link-format stream parser.
// Slave side: one payload byte per transfer. s_tdata carries the byte,
// s_tuser the mode (data byte, final data byte, or end of payload with no
// byte; the byte is ignored then).
// Master side: one event per transfer. m_tuser is the event kind, m_tdata
// the character for path, name and value events (zero otherwise), m_tlast
// marks the last event caused by one input byte. End of payload yields an
// optional attribute end followed by an ok or error status.
// Events of a byte are registered and appear on the master side the cycle
// after its transfer. Throughput is one byte per cycle while each byte causes
// at most one event and m_tready is high; a byte causing more events holds
// s_tready low while the output register drains them one per transfer.
// Bytes that cause no event (opening brackets, separators after a resource,
// data bytes in the error state) leave nothing on the master side.
// Reset clears the parser to its start state and empties the output.
// When the receiver stalls, the pending events hold and s_tready stays low
// until the last of them can leave.
module link_format_stream_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic [1:0] s_tuser,   // mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // event_byte
	output logic [2:0] m_tuser,   // event_kind
	output logic       m_tlast    // last_of_run
);
	import lfsp_pkg::*;

	bundle_t bundle;
	logic    accept;

	assign accept = s_tvalid && s_tready;

	lfsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (s_tuser),
		.data_byte (s_tdata),
		.bundle    (bundle)
	);

	lfsp_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.bundle   (bundle),
		.take_ok  (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfsp_pkg::*;

	// mode 2 is the documented end of payload, 3 is unused and must act the same
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int N_ITEMS = 410;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [1:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	link_format_stream_parser_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] chr;
		logic       last;
	} link_event_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       known;   // events below are fixed by hand
		logic [1:0] n;
		logic [2:0] kind;    // kind of the last event
		logic [7:0] chr;
	} stim_row_t;

	localparam stim_row_t DIRECTED [28] = '{
		'{MODE_END,   8'h00,    1'b1, 2'd1, EV_OK,       8'h00},  // empty payload
		'{MODE_DATA,  8'h61,    1'b1, 2'd0, EV_PATH,     8'h00},  // 'a' without bracket
		'{MODE_FINAL, 8'h00,    1'b1, 2'd1, EV_ERROR,    8'h00},
		'{MODE_DATA,  CH_LT,    1'b1, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  8'h00,    1'b1, 2'd1, EV_PATH,     8'h00},
		'{MODE_DATA,  8'hFF,    1'b1, 2'd1, EV_PATH,     8'hFF},
		'{MODE_DATA,  CH_GT,    1'b1, 2'd1, EV_RES_END,  8'h00},
		'{MODE_DATA,  CH_SEMI,  1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_SEMI,  1'b1, 2'd1, EV_ATTR_END, 8'h00},  // empty name, no value
		'{MODE_DATA,  8'h72,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_EQ,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_QUOTE, 1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  8'h80,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_QUOTE, 1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  8'h71,    1'b1, 2'd0, EV_PATH,     8'h00},  // bad separator
		'{MODE_END,   8'hFF,    1'b1, 2'd1, EV_ERROR,    8'h00},
		'{MODE_DATA,  CH_LT,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_GT,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_SEMI,  1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  8'h6E,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_EQ,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_FINAL, 8'h76,    1'b1, 2'd3, EV_OK,       8'h00},  // value, attr end, ok
		'{MODE_DATA,  CH_LT,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_GT,    1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_SEMI,  1'b0, 2'd0, EV_PATH,     8'h00},
		'{MODE_DATA,  CH_EQ,    1'b1, 2'd0, EV_PATH,     8'h00},  // '=' with empty name
		'{MODE_SPARE, 8'hFF,    1'b1, 2'd1, EV_ERROR,    8'h00},
		'{MODE_FINAL, CH_LT,    1'b1, 2'd1, EV_ERROR,    8'h00}   // open path at end
	};

	// parser shadow state
	pstate_t     ps;
	logic        got_name;
	logic [2:0]  run_kind [3];
	logic [7:0]  run_chr [3];
	int          run_n;

	link_event_t pending_ev [$];
	link_event_t got_ev;
	logic [7:0]  frame [$];
	int          n_err;
	int          n_sent;
	logic        calm;

	function automatic void add_ev(input logic [2:0] k, input logic [7:0] c);
		run_kind[run_n] = k;
		run_chr[run_n] = c;
		run_n++;
	endfunction

	function automatic void parse_byte(input logic [7:0] c);
		case (ps)
			ST_START: ps = (c == CH_LT) ? ST_PATH : ST_ERROR;
			ST_PATH: begin
				if (c == CH_GT) begin
					add_ev(EV_RES_END, 8'h00);
					ps = ST_AFTER_RES;
				end else
					add_ev(EV_PATH, c);
			end
			ST_AFTER_RES: begin
				got_name = 1'b0;
				if (c == CH_SEMI)
					ps = ST_NAME;
				else if (c == CH_COMMA)
					ps = ST_START;
				else
					ps = ST_ERROR;
			end
			ST_NAME: begin
				if (c == CH_EQ)
					ps = got_name ? ST_VAL_FIRST : ST_ERROR;
				else if (c == CH_SEMI) begin
					add_ev(EV_ATTR_END, 8'h00);
					got_name = 1'b0;
				end else if (c == CH_COMMA) begin
					add_ev(EV_ATTR_END, 8'h00);
					ps = ST_START;
				end else begin
					add_ev(EV_NAME, c);
					got_name = 1'b1;
				end
			end
			ST_VAL_FIRST, ST_VAL_PLAIN: begin
				if (ps == ST_VAL_FIRST && c == CH_QUOTE)
					ps = ST_VAL_QUOTED;
				else if (c == CH_COMMA) begin
					add_ev(EV_ATTR_END, 8'h00);
					ps = ST_START;
				end else if (c == CH_SEMI) begin
					add_ev(EV_ATTR_END, 8'h00);
					got_name = 1'b0;
					ps = ST_NAME;
				end else begin
					add_ev(EV_VALUE, c);
					ps = ST_VAL_PLAIN;
				end
			end
			ST_VAL_QUOTED: begin
				if (c == CH_QUOTE) begin
					add_ev(EV_ATTR_END, 8'h00);
					ps = ST_AFTER_RES;
				end else
					add_ev(EV_VALUE, c);
			end
			default: ps = ST_ERROR;
		endcase
	endfunction

	function automatic void close_payload();
		logic ok;
		ok = 1'b1;
		case (ps)
			ST_START, ST_AFTER_RES: ;
			ST_NAME: if (got_name) add_ev(EV_ATTR_END, 8'h00);
			ST_VAL_FIRST, ST_VAL_PLAIN: add_ev(EV_ATTR_END, 8'h00);
			default: ok = 1'b0;
		endcase
		add_ev(ok ? EV_OK : EV_ERROR, 8'h00);
		ps = ST_START;
		got_name = 1'b0;
	endfunction

	// events one accepted byte must produce, queued in order
	function automatic void predict_events(input logic [1:0] mode, input logic [7:0] c);
		link_event_t nxt;
		run_n = 0;
		if (mode == MODE_DATA || mode == MODE_FINAL)
			parse_byte(c);
		if (mode != MODE_DATA)
			close_payload();
		for (int i = 0; i < run_n; i++) begin
			nxt = '{run_kind[i], run_chr[i], i == run_n - 1};
			pending_ev = {pending_ev, nxt};
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_ev.size() == 0) begin
					$error("unexpected event: kind %0d byte %02h last %0b",
						m_tuser, m_tdata, m_tlast);
					n_err++;
				end else begin
					got_ev = pending_ev.pop_front();
					if (m_tuser !== got_ev.kind) begin
						$error("event_kind: expected %0d, got %0d", got_ev.kind, m_tuser);
						n_err++;
					end
					if (m_tdata !== got_ev.chr) begin
						$error("event_byte: expected %02h, got %02h", got_ev.chr, m_tdata);
						n_err++;
					end
					if (m_tlast !== got_ev.last) begin
						$error("last_of_run: expected %0b, got %0b", got_ev.last, m_tlast);
						n_err++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_events(s_tuser, s_tdata);
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= 23);
	end

	task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
		while (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= data;
		do
			@(posedge clk);
		while (!s_tready);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] z);
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == x || c == y || c == z);
		return c;
	endfunction

	// delimiter-heavy junk
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(7))
			0: return CH_LT;
			1: return CH_GT;
			2: return CH_SEMI;
			3: return CH_COMMA;
			4: return CH_EQ;
			5: return CH_QUOTE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		frame = {frame, b};
	endfunction

	// mostly well-formed link lists, some corrupted, truncated or pure junk
	task automatic build_frame();
		int n_ent;
		int n_len;
		frame.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(8, 1)) add_byte(noise_byte());
			return;
		end
		n_ent = $urandom_range(3, 1);
		for (int r = 0; r < n_ent; r++) begin
			if (r != 0)
				add_byte(CH_COMMA);
			add_byte(CH_LT);
			repeat ($urandom_range(4)) add_byte(pick(CH_GT, CH_GT, CH_GT));
			add_byte(CH_GT);
			repeat ($urandom_range(3)) begin
				add_byte(CH_SEMI);
				n_len = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
				repeat (n_len) add_byte(pick(CH_EQ, CH_SEMI, CH_COMMA));
				case ($urandom_range(3))
					0: ;
					1: add_byte(CH_EQ);
					2: begin
						add_byte(CH_EQ);
						repeat ($urandom_range(4, 1))
							add_byte(pick(CH_COMMA, CH_SEMI, CH_QUOTE));
					end
					default: begin
						add_byte(CH_EQ);
						add_byte(CH_QUOTE);
						repeat ($urandom_range(4))
							add_byte(pick(CH_QUOTE, CH_QUOTE, CH_QUOTE));
						add_byte(CH_QUOTE);
					end
				endcase
			end
		end
		if ($urandom_range(4) == 0)
			frame[$urandom_range(frame.size() - 1)] = noise_byte();
		if ($urandom_range(9) == 0) begin
			n_len = $urandom_range(frame.size() - 1);
			while (frame.size() > n_len)
				void'(frame.pop_back());
		end
	endtask

	initial begin
		int ending;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = MODE_DATA;
		m_tready = 1'b0;
		calm     = 1'b0;
		n_err    = 0;
		n_sent   = 0;
		ps       = ST_START;
		got_name = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			send_item(DIRECTED[i].mode, DIRECTED[i].data);
			// shadow state was updated at the accepting edge
			if (DIRECTED[i].known && (run_n != DIRECTED[i].n ||
					(run_n != 0 && (run_kind[run_n-1] != DIRECTED[i].kind ||
					run_chr[run_n-1] != DIRECTED[i].chr)))) begin
				$error("row %0d: expected %0d events ending in kind %0d, got %0d",
					i, DIRECTED[i].n, DIRECTED[i].kind, run_n);
				n_err++;
			end
		end

		while (n_sent < N_ITEMS) begin
			calm = (n_sent >= 150 && n_sent < 230);
			build_frame();
			ending = (frame.size() == 0) ? 1 : $urandom_range(2);
			foreach (frame[i])
				send_item((ending == 0 && i == frame.size() - 1) ? MODE_FINAL : MODE_DATA,
					frame[i]);
			if (ending == 1)
				send_item(MODE_END, 8'($urandom));
			else if (ending == 2)
				send_item(MODE_SPARE, 8'($urandom));
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_ev.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_err == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
